// File: rtl/fqsa_pkg.sv
`default_nettype none
package fqsa_pkg;
  localparam int unsigned NumProcsDef  = 16;
  localparam int unsigned NumLevelsDef = 5;
  localparam int unsigned QuantW  = 4;
  localparam int unsigned AgeW    = 6;
  localparam int unsigned OpW     = 2;
  localparam int unsigned IdW     = 4;
  localparam int unsigned StatusW = 3;
  localparam int unsigned PriW    = 3;
  localparam int unsigned CfgIdxW = 1;
  localparam int unsigned CfgDataW = 6;
  localparam logic [QuantW-1:0] QuantRst = 4'd5;
  localparam logic [AgeW-1:0]   AgeRst   = 6'd20;
  localparam logic [AgeW-1:0]   WaitMax  = 6'd63;

  typedef enum logic [OpW-1:0] {
    OP_TICK = 2'd0, OP_IOREQ = 2'd1, OP_IODONE = 2'd2, OP_ADMIT = 2'd3
  } op_e;

  typedef enum logic [StatusW-1:0] {
    ST_NONE = 3'd0, ST_DISPATCH = 3'd1, ST_IDLE = 3'd2, ST_WOKEN = 3'd3,
    ST_BLK_EMPTY = 3'd4, ST_ADMIT = 3'd5, ST_REJECT = 3'd6
  } status_e;

  typedef enum logic [1:0] {
    PS_ABSENT = 2'd0, PS_READY = 2'd1, PS_RUNNING = 2'd2, PS_BLOCKED = 2'd3
  } pstat_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_QUANTUM = 1'd0, CFG_AGE = 1'd1
  } cfg_e;

  typedef enum logic [2:0] {
    S_IDLE, S_AGE_LVL, S_AGE_POP, S_RUN, S_DISP, S_OUT
  } state_e;

  typedef struct packed {
    logic [IdW-1:0]     current_id;
    logic               current_valid;
    logic [StatusW-1:0] status;
    logic [IdW-1:0]     affected_id;
    logic [PriW-1:0]    affected_priority;
  } result_t;
endpackage
`default_nettype wire

// File: rtl/fqsa_if.sv
`default_nettype none
interface fqsa_in_if;
  logic                         valid;
  logic                         ready;
  logic [fqsa_pkg::OpW-1:0]     op;
  logic [fqsa_pkg::IdW-1:0]     proc_id;
  modport source (output valid, op, proc_id, input ready);
  modport sink (input valid, op, proc_id, output ready);
endinterface

interface fqsa_out_if;
  logic                         valid;
  logic                         ready;
  logic [fqsa_pkg::IdW-1:0]     current_id;
  logic                         current_valid;
  logic [fqsa_pkg::StatusW-1:0] status;
  logic [fqsa_pkg::IdW-1:0]     affected_id;
  logic [fqsa_pkg::PriW-1:0]    affected_priority;
  modport source (output valid, current_id, current_valid, status, affected_id,
                  affected_priority, input ready);
  modport sink (input valid, current_id, current_valid, status, affected_id,
                affected_priority, output ready);
endinterface
`default_nettype wire

// File: rtl/fqsa_wait_unit.sv
`default_nettype none
// saturating wait increment and promotion compare, shared by all aging steps
module fqsa_wait_unit (
  input  wire logic [fqsa_pkg::AgeW-1:0] wait_i,
  input  wire logic [fqsa_pkg::AgeW-1:0] limit_i,
  input  wire logic                      not_top_i,
  output logic [fqsa_pkg::AgeW-1:0]      wait_o,
  output logic                           promote_o
);
  logic [fqsa_pkg::AgeW-1:0] inc;
  always_comb begin
    inc = (wait_i == fqsa_pkg::WaitMax) ? wait_i : wait_i + 1'b1;
    promote_o = not_top_i && (inc > limit_i);
    wait_o = promote_o ? '0 : inc;
  end
endmodule
`default_nettype wire

// File: rtl/feedback_queue_scheduler_aging.sv
`default_nettype none
// Multilevel feedback queue scheduler with aging. Items are taken on in_if and one
// result word per item leaves on out_if. Admit, IO completion and a tick that does
// not expire need no scheduling pass; a scheduling pass walks every ready entry
// through one shared wait unit, one entry per cycle, level by level. in_if.ready is
// low while an item is in work or its result waits. No clearing pass after reset.
module feedback_queue_scheduler_aging #(
  parameter int unsigned NUM_PROCS  = fqsa_pkg::NumProcsDef,
  parameter int unsigned NUM_LEVELS = fqsa_pkg::NumLevelsDef
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_we_i,
  input  wire logic [fqsa_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [fqsa_pkg::CfgDataW-1:0] cfg_data_i,
  fqsa_in_if.sink                            in_if,
  fqsa_out_if.source                         out_if
);
  localparam int unsigned PW = (NUM_PROCS > 1) ? $clog2(NUM_PROCS) : 1;
  localparam int unsigned LW = (NUM_LEVELS > 1) ? $clog2(NUM_LEVELS) : 1;
  localparam int unsigned CW = $clog2(NUM_PROCS + 1);
  localparam int unsigned AW = fqsa_pkg::AgeW;
  localparam int unsigned IW = fqsa_pkg::IdW;

  fqsa_pkg::state_e state_q, state_d;
  logic [fqsa_pkg::QuantW-1:0] quant_q;
  logic [AW-1:0] age_q;

  logic [1:0]    pstat_q [NUM_PROCS];
  logic [LW-1:0] plvl_q  [NUM_PROCS];
  logic [AW-1:0] pwait_q [NUM_PROCS];
  logic [PW-1:0] link_q  [NUM_PROCS];
  logic [PW-1:0] rhead_q [NUM_LEVELS];
  logic [PW-1:0] rtail_q [NUM_LEVELS];
  logic [NUM_LEVELS-1:0] rempty_q;
  logic [PW-1:0] bhead_q, btail_q;
  logic bempty_q;
  logic [PW-1:0] run_id_q;
  logic run_v_q;
  logic [fqsa_pkg::QuantW-1:0] ticks_q;

  logic [LW-1:0] lvl_q;
  logic [CW-1:0] cnt_q;
  logic [PW-1:0] cur_q;
  logic [PW-1:0] stop_q;
  logic io_q;
  logic out_v_q;
  fqsa_pkg::result_t res_q;

  // one aging step
  logic [AW-1:0] w_new;
  logic promote;
  fqsa_wait_unit u_wait (
    .wait_i(pwait_q[cur_q]), .limit_i(age_q), .not_top_i(lvl_q != '0),
    .wait_o(w_new), .promote_o(promote)
  );

  assign in_if.ready = (state_q == fqsa_pkg::S_IDLE) && !out_v_q;
  assign out_if.valid = out_v_q;
  assign out_if.current_id = res_q.current_id;
  assign out_if.current_valid = res_q.current_valid;
  assign out_if.status = res_q.status;
  assign out_if.affected_id = res_q.affected_id;
  assign out_if.affected_priority = res_q.affected_priority;

  logic acc;
  assign acc = in_if.valid && in_if.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= fqsa_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      fqsa_pkg::S_IDLE: begin
        if (acc) begin
          if ((fqsa_pkg::op_e'(in_if.op) == fqsa_pkg::OP_IOREQ) ||
              ((fqsa_pkg::op_e'(in_if.op) == fqsa_pkg::OP_TICK) &&
               (!run_v_q || ticks_q <= 4'd1))) begin
            state_d = fqsa_pkg::S_AGE_LVL;
          end
        end
      end
      fqsa_pkg::S_AGE_LVL: begin
        if (!rempty_q[lvl_q]) begin
          state_d = fqsa_pkg::S_AGE_POP;
        end else if (lvl_q == LW'(NUM_LEVELS - 1)) begin
          state_d = fqsa_pkg::S_RUN;
        end
      end
      fqsa_pkg::S_AGE_POP: begin
        if (cur_q == stop_q || cnt_q == CW'(NUM_PROCS - 1)) begin
          state_d = (lvl_q == LW'(NUM_LEVELS - 1)) ? fqsa_pkg::S_RUN
                                                   : fqsa_pkg::S_AGE_LVL;
        end
      end
      fqsa_pkg::S_RUN: state_d = fqsa_pkg::S_DISP;
      fqsa_pkg::S_DISP: state_d = fqsa_pkg::S_IDLE;
      default: state_d = fqsa_pkg::S_IDLE;
    endcase
  end

  // lowest-numbered (highest-priority) nonempty level, for dispatch
  logic [LW-1:0] top_lvl;
  logic top_any;
  always_comb begin
    top_lvl = '0;
    top_any = 1'b0;
    for (int l = NUM_LEVELS - 1; l >= 0; l--) begin
      if (!rempty_q[l]) begin
        top_lvl = LW'(l);
        top_any = 1'b1;
      end
    end
  end

  logic [PW-1:0] pid;
  logic [LW-1:0] nl;
  logic [PW-1:0] dh;
  assign pid = PW'(in_if.proc_id);
  assign dh = rhead_q[top_lvl];
  assign nl = (plvl_q[run_id_q] == LW'(NUM_LEVELS - 1)) ? plvl_q[run_id_q]
                                                       : plvl_q[run_id_q] + 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      quant_q <= fqsa_pkg::QuantRst;
      age_q <= fqsa_pkg::AgeRst;
      for (int i = 0; i < NUM_PROCS; i++) begin
        pstat_q[i] <= fqsa_pkg::PS_ABSENT;
        plvl_q[i] <= '0;
        pwait_q[i] <= '0;
      end
      for (int l = 0; l < NUM_LEVELS; l++) begin
        rhead_q[l] <= '0;
        rtail_q[l] <= '0;
      end
      rempty_q <= '1;
      bhead_q <= '0;
      btail_q <= '0;
      bempty_q <= 1'b1;
      run_id_q <= '0;
      run_v_q <= 1'b0;
      ticks_q <= '0;
      lvl_q <= '0;
      cnt_q <= '0;
      cur_q <= '0;
      stop_q <= '0;
      io_q <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (fqsa_pkg::cfg_e'(cfg_idx_i))
          fqsa_pkg::CFG_QUANTUM: quant_q <= cfg_data_i[fqsa_pkg::QuantW-1:0];
          fqsa_pkg::CFG_AGE: age_q <= cfg_data_i;
          default: ;
        endcase
      end
      if (out_v_q && out_if.ready) begin
        out_v_q <= 1'b0;
      end
      case (state_q)
        fqsa_pkg::S_IDLE: begin
          if (acc) begin
            res_q.current_id <= run_v_q ? IW'(run_id_q) : '0;
            res_q.current_valid <= run_v_q;
            res_q.status <= fqsa_pkg::ST_NONE;
            res_q.affected_id <= '0;
            res_q.affected_priority <= '0;
            lvl_q <= '0;
            io_q <= (fqsa_pkg::op_e'(in_if.op) == fqsa_pkg::OP_IOREQ);
            case (fqsa_pkg::op_e'(in_if.op))
              fqsa_pkg::OP_TICK: begin
                if (run_v_q && ticks_q > 4'd1) begin
                  ticks_q <= ticks_q - 1'b1;
                  out_v_q <= 1'b1;
                end
              end
              fqsa_pkg::OP_IOREQ: ;
              fqsa_pkg::OP_IODONE: begin
                out_v_q <= 1'b1;
                if (bempty_q) begin
                  res_q.status <= fqsa_pkg::ST_BLK_EMPTY;
                end else begin
                  if (bhead_q == btail_q) bempty_q <= 1'b1;
                  else bhead_q <= link_q[bhead_q];
                  pstat_q[bhead_q] <= fqsa_pkg::PS_READY;
                  if (rempty_q[plvl_q[bhead_q]]) begin
                    rhead_q[plvl_q[bhead_q]] <= bhead_q;
                    rempty_q[plvl_q[bhead_q]] <= 1'b0;
                  end else begin
                    link_q[rtail_q[plvl_q[bhead_q]]] <= bhead_q;
                  end
                  rtail_q[plvl_q[bhead_q]] <= bhead_q;
                  res_q.status <= fqsa_pkg::ST_WOKEN;
                  res_q.affected_id <= IW'(bhead_q);
                  res_q.affected_priority <= 3'(plvl_q[bhead_q]);
                end
              end
              default: begin
                out_v_q <= 1'b1;
                if (32'(in_if.proc_id) >= NUM_PROCS || pstat_q[pid] != fqsa_pkg::PS_ABSENT) begin
                  res_q.status <= fqsa_pkg::ST_REJECT;
                end else begin
                  pstat_q[pid] <= fqsa_pkg::PS_READY;
                  plvl_q[pid] <= '0;
                  pwait_q[pid] <= '0;
                  if (rempty_q[0]) begin
                    rhead_q[0] <= pid;
                    rempty_q[0] <= 1'b0;
                  end else begin
                    link_q[rtail_q[0]] <= pid;
                  end
                  rtail_q[0] <= pid;
                  res_q.status <= fqsa_pkg::ST_ADMIT;
                  res_q.affected_id <= in_if.proc_id;
                end
              end
            endcase
          end
        end
        fqsa_pkg::S_AGE_LVL: begin
          if (!rempty_q[lvl_q]) begin
            // snapshot the level: pop to the original tail
            cur_q <= rhead_q[lvl_q];
            stop_q <= rtail_q[lvl_q];
            cnt_q <= '0;
          end else if (lvl_q != LW'(NUM_LEVELS - 1)) begin
            lvl_q <= lvl_q + 1'b1;
          end
        end
        fqsa_pkg::S_AGE_POP: begin
          // pop cur from head, then push it to its target tail
          begin
            logic [LW-1:0] tl;
            logic last;
            logic em_after;
            logic [PW-1:0] hd_after;
            last = (cur_q == stop_q) || (cnt_q == CW'(NUM_PROCS - 1));
            tl = promote ? lvl_q - 1'b1 : lvl_q;
            em_after = (rhead_q[lvl_q] == rtail_q[lvl_q]);
            hd_after = link_q[cur_q];
            pwait_q[cur_q] <= w_new;
            if (promote) plvl_q[cur_q] <= tl;
            if (!promote) begin
              if (em_after) begin
                rhead_q[lvl_q] <= cur_q;
              end else begin
                rhead_q[lvl_q] <= hd_after;
                link_q[rtail_q[lvl_q]] <= cur_q;
              end
              rtail_q[lvl_q] <= cur_q;
            end else begin
              if (em_after) rempty_q[lvl_q] <= 1'b1;
              else rhead_q[lvl_q] <= hd_after;
              if (rempty_q[tl]) begin
                rhead_q[tl] <= cur_q;
                rempty_q[tl] <= 1'b0;
              end else begin
                link_q[rtail_q[tl]] <= cur_q;
              end
              rtail_q[tl] <= cur_q;
            end
            cnt_q <= cnt_q + 1'b1;
            if (!last) cur_q <= hd_after;
            else if (lvl_q != LW'(NUM_LEVELS - 1)) lvl_q <= lvl_q + 1'b1;
          end
        end
        fqsa_pkg::S_RUN: begin
          if (run_v_q) begin
            if (io_q) begin
              pstat_q[run_id_q] <= fqsa_pkg::PS_BLOCKED;
              if (bempty_q) begin
                bhead_q <= run_id_q;
                bempty_q <= 1'b0;
              end else begin
                link_q[btail_q] <= run_id_q;
              end
              btail_q <= run_id_q;
            end else begin
              plvl_q[run_id_q] <= nl;
              pstat_q[run_id_q] <= fqsa_pkg::PS_READY;
              if (rempty_q[nl]) begin
                rhead_q[nl] <= run_id_q;
                rempty_q[nl] <= 1'b0;
              end else begin
                link_q[rtail_q[nl]] <= run_id_q;
              end
              rtail_q[nl] <= run_id_q;
            end
            run_v_q <= 1'b0;
          end
        end
        fqsa_pkg::S_DISP: begin
          out_v_q <= 1'b1;
          if (top_any) begin
            if (rhead_q[top_lvl] == rtail_q[top_lvl]) rempty_q[top_lvl] <= 1'b1;
            else rhead_q[top_lvl] <= link_q[dh];
            run_id_q <= dh;
            run_v_q <= 1'b1;
            pstat_q[dh] <= fqsa_pkg::PS_RUNNING;
            pwait_q[dh] <= '0;
            ticks_q <= quant_q;
            res_q.current_id <= IW'(dh);
            res_q.current_valid <= 1'b1;
            res_q.status <= fqsa_pkg::ST_DISPATCH;
            res_q.affected_id <= IW'(dh);
            res_q.affected_priority <= 3'(plvl_q[dh]);
          end else begin
            res_q.current_id <= '0;
            res_q.current_valid <= 1'b0;
            res_q.status <= fqsa_pkg::ST_IDLE;
          end
        end
        default: ;
      endcase
    end
  end
endmodule
`default_nettype wire

// File: rtl/fqsa_checker.sv
`default_nettype none
module fqsa_checker (
  input wire logic clk_i,
  input wire logic rst_ni,
  input wire logic in_ready,
  input wire logic out_valid,
  input wire logic out_ready,
  input wire logic cur_valid,
  input wire logic [fqsa_pkg::IdW-1:0] cur_id,
  input wire logic [fqsa_pkg::StatusW-1:0] status
);
  a_no_accept_while_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid |-> !in_ready) else $error("input taken while word pending");
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid && $stable(status))
    else $error("output word dropped");
  a_idle_id: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !cur_valid |-> cur_id == '0) else $error("idle id nonzero");
  a_status_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid |-> status != 3'd7) else $error("bad status");
  a_idle_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && status == fqsa_pkg::ST_IDLE |-> !cur_valid)
    else $error("idle yet running");
endmodule

bind feedback_queue_scheduler_aging fqsa_checker u_fqsa_checker (
  .clk_i(clk_i), .rst_ni(rst_ni),
  .in_ready(in_if.ready),
  .out_valid(out_if.valid), .out_ready(out_if.ready),
  .cur_valid(out_if.current_valid), .cur_id(out_if.current_id),
  .status(out_if.status)
);
`default_nettype wire

// File: test/testbench.sv
module testbench;
  import fqsa_pkg::*;

  localparam int NP = 16;
  localparam int NL = 5;
  localparam int BLKQ = NL;  // blocked queue sits after the ready levels
  localparam int LIMIT = 400000;

  class sched_board;
    logic [QuantW-1:0] quantum;
    logic [AgeW-1:0] age_lim;
    pstat_e pstat[NP];
    logic [2:0] lvl[NP];
    logic [5:0] wt[NP];
    logic [3:0] link[NP];
    logic [3:0] qhead[NL+1];
    logic [3:0] qtail[NL+1];
    bit qempty[NL+1];
    logic [3:0] run_id;
    bit run_v;
    logic [QuantW-1:0] ticks;
    result_t pending[$];
    int errors;

    function new();
      quantum = QuantRst;
      age_lim = AgeRst;
      for (int i = 0; i < NP; i++) begin
        pstat[i] = PS_ABSENT;
        lvl[i] = 0;
        wt[i] = 0;
        link[i] = 0;
      end
      for (int q = 0; q <= NL; q++) begin
        qhead[q] = 0;
        qtail[q] = 0;
        qempty[q] = 1;
      end
      run_id = 0;
      run_v = 0;
      ticks = 0;
      errors = 0;
    endfunction

    function void push(int q, logic [3:0] id);
      if (qempty[q]) begin
        qhead[q] = id;
        qempty[q] = 0;
      end else begin
        link[qtail[q]] = id;
      end
      qtail[q] = id;
    endfunction

    function int pop(int q);
      logic [3:0] id;
      if (qempty[q]) return -1;
      id = qhead[q];
      if (id == qtail[q]) qempty[q] = 1;
      else qhead[q] = link[id];
      return int'(id);
    endfunction

    function void age_ready();
      logic [3:0] lst[$];
      int id;
      for (int l = 0; l < NL; l++) begin
        lst.delete();
        id = pop(l);
        while (id >= 0) begin
          lst = {lst, id[3:0]};
          id = pop(l);
        end
        foreach (lst[k]) begin
          if (wt[lst[k]] < WaitMax) wt[lst[k]]++;
          if (wt[lst[k]] > age_lim && l > 0) begin
            lvl[lst[k]] = 3'(l - 1);
            wt[lst[k]] = 0;
            push(l - 1, lst[k]);
          end else begin
            push(l, lst[k]);
          end
        end
      end
    endfunction

    function status_e pass(bit io, output logic [3:0] aid, output logic [2:0] apri);
      int id;
      int nl;
      aid = 0;
      apri = 0;
      age_ready();
      if (run_v) begin
        if (io) begin
          pstat[run_id] = PS_BLOCKED;
          push(BLKQ, run_id);
        end else begin
          nl = lvl[run_id] + 1;
          if (nl >= NL) nl = NL - 1;
          lvl[run_id] = 3'(nl);
          pstat[run_id] = PS_READY;
          push(nl, run_id);
        end
        run_v = 0;
      end
      for (int l = 0; l < NL; l++) begin
        id = pop(l);
        if (id >= 0) begin
          run_id = id[3:0];
          run_v = 1;
          pstat[id] = PS_RUNNING;
          wt[id] = 0;
          ticks = quantum;
          aid = id[3:0];
          apri = lvl[id];
          return ST_DISPATCH;
        end
      end
      return ST_IDLE;
    endfunction

    function void note_word(op_e op, logic [3:0] pid);
      result_t r;
      status_e st;
      logic [3:0] aid;
      logic [2:0] apri;
      int id;
      st = ST_NONE;
      aid = 0;
      apri = 0;
      case (op)
        OP_TICK: begin
          if (!run_v || ticks <= 1) st = pass(0, aid, apri);
          else ticks--;
        end
        OP_IOREQ: st = pass(1, aid, apri);
        OP_IODONE: begin
          id = pop(BLKQ);
          if (id < 0) begin
            st = ST_BLK_EMPTY;
          end else begin
            pstat[id] = PS_READY;
            push(lvl[id], id[3:0]);
            st = ST_WOKEN;
            aid = id[3:0];
            apri = lvl[id];
          end
        end
        default: begin
          if (pstat[pid] != PS_ABSENT) begin
            st = ST_REJECT;
          end else begin
            pstat[pid] = PS_READY;
            lvl[pid] = 0;
            wt[pid] = 0;
            push(0, pid);
            st = ST_ADMIT;
            aid = pid;
          end
        end
      endcase
      r.current_id = run_v ? run_id : 4'd0;
      r.current_valid = run_v;
      r.status = st;
      r.affected_id = aid;
      r.affected_priority = apri;
      pending = {pending, r};
    endfunction

    function void check_word(result_t got);
      result_t e;
      if (pending.size() == 0) begin
        errors++;
        $display("%0t: unexpected word %h", $time, got);
        return;
      end
      e = pending.pop_front();
      if (got.current_id !== e.current_id) begin
        errors++;
        $display("%0t: current_id exp %0d got %0d", $time, e.current_id, got.current_id);
      end
      if (got.current_valid !== e.current_valid) begin
        errors++;
        $display("%0t: current_valid exp %0d got %0d", $time, e.current_valid,
                 got.current_valid);
      end
      if (got.status !== e.status) begin
        errors++;
        $display("%0t: status exp %0d got %0d", $time, e.status, got.status);
      end
      if (got.affected_id !== e.affected_id) begin
        errors++;
        $display("%0t: affected_id exp %0d got %0d", $time, e.affected_id, got.affected_id);
      end
      if (got.affected_priority !== e.affected_priority) begin
        errors++;
        $display("%0t: affected_priority exp %0d got %0d", $time, e.affected_priority,
                 got.affected_priority);
      end
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;
  logic cfg_we_i;
  logic [CfgIdxW-1:0] cfg_idx_i;
  logic [CfgDataW-1:0] cfg_data_i;
  fqsa_in_if in_b();
  fqsa_out_if out_b();

  feedback_queue_scheduler_aging u_dut (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .cfg_we_i(cfg_we_i),
    .cfg_idx_i(cfg_idx_i),
    .cfg_data_i(cfg_data_i),
    .in_if(in_b),
    .out_if(out_b)
  );

  sched_board sched = new();
  bit quiet;
  int hold_left;
  int stall_left;
  int cycles;

  always begin
    clk_i = 1'b1;
    #10;
    clk_i = 1'b0;
    #10;
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // result side: checks and random back-pressure
  initial begin
    result_t got;
    out_b.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_b.valid && out_b.ready) begin
        got.current_id = out_b.current_id;
        got.current_valid = out_b.current_valid;
        got.status = out_b.status;
        got.affected_id = out_b.affected_id;
        got.affected_priority = out_b.affected_priority;
        sched.check_word(got);
      end
      if (hold_left > 0) begin
        hold_left--;
        out_b.ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_b.ready <= 1'b0;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
        stall_left = $urandom_range(0, 6);
        out_b.ready <= 1'b0;
      end else begin
        out_b.ready <= 1'b1;
      end
    end
  end

  task automatic send_word(op_e op, logic [3:0] pid);
    int gap;
    in_b.valid <= 1'b1;
    in_b.op <= op;
    in_b.proc_id <= pid;
    @(posedge clk_i);
    while (!in_b.ready) @(posedge clk_i);
    sched.note_word(op, pid);
    if (!quiet && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 7);
      in_b.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic drain();
    in_b.valid <= 1'b0;
    while (sched.pending.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
  endtask

  task automatic write_regs(logic [QuantW-1:0] q, logic [AgeW-1:0] a);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= CFG_QUANTUM;
    cfg_data_i <= CfgDataW'(q);
    @(posedge clk_i);
    cfg_idx_i <= CFG_AGE;
    cfg_data_i <= a;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    sched.quantum = q;
    sched.age_lim = a;
  endtask

  task automatic random_words(int n);
    int pick;
    for (int i = 0; i < n; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < 45) send_word(OP_TICK, 4'($urandom));
      else if (pick < 65) send_word(OP_IOREQ, 4'($urandom));
      else if (pick < 85) send_word(OP_IODONE, 4'($urandom));
      else send_word(OP_ADMIT, 4'($urandom_range(0, 15)));
    end
  endtask

  initial begin
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = CFG_QUANTUM;
    cfg_data_i = '0;
    in_b.valid = 1'b0;
    in_b.op = OP_TICK;
    in_b.proc_id = '0;
    quiet = 0;
    hold_left = 0;
    stall_left = 0;
    cycles = 0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: empty wake, idle tick and io, admits at both ends, reject
    send_word(OP_IODONE, 4'd0);
    send_word(OP_TICK, 4'd0);
    send_word(OP_IOREQ, 4'd0);
    send_word(OP_ADMIT, 4'd0);
    send_word(OP_ADMIT, 4'd15);
    send_word(OP_ADMIT, 4'd0);
    send_word(OP_TICK, 4'd0);
    send_word(OP_TICK, 4'd0);
    send_word(OP_IOREQ, 4'd0);
    send_word(OP_IOREQ, 4'd0);
    send_word(OP_IOREQ, 4'd0);
    send_word(OP_IODONE, 4'd0);
    send_word(OP_IODONE, 4'd0);
    send_word(OP_ADMIT, 4'd10);
    send_word(OP_ADMIT, 4'd5);
    for (int i = 0; i < 8; i++) send_word(OP_TICK, 4'd0);
    drain();

    // pressure: results held back while words keep coming
    hold_left = 300;
    random_words(350);
    drain();

    write_regs(4'd1, 6'd1);
    random_words(350);
    drain();

    write_regs(4'd15, 6'd62);
    random_words(350);
    drain();

    write_regs(4'($urandom_range(1, 15)), 6'($urandom_range(1, 62)));
    random_words(200);
    quiet = 1;
    random_words(200);
    drain();

    if (sched.errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end
endmodule
